// File: rtl/uwo_pkg.sv
// shared types and constants of the unison wavetable oscillator
package uwo_pkg;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_RATIO  = 2'd2,
        KIND_PHASE  = 2'd3
    } t_kind;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETUNE_AMOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LEVEL  = 2'd2;

    localparam int PHASE_W  = 32;
    localparam int RATIO_W  = 24;
    localparam int SAMPLE_W = 16;
    localparam int ENTRY_W  = 11;
    localparam int COUNT_W  = 5;
    localparam int GAIN_W   = 16;

    localparam logic [RATIO_W-1:0] UNITY_RATIO = 24'd4194304;

    localparam logic [COUNT_W-1:0] RST_VOICE_COUNT = 5'd1;
    localparam logic [GAIN_W-1:0]  RST_GAIN        = 16'd32768;

endpackage

// File: rtl/uwo_in_if.sv
// input word channel: tick or table, ratio and phase writes
interface uwo_in_if;
    import uwo_pkg::*;

    logic                       valid;
    logic                       ready;
    t_kind                      kind;
    logic [PHASE_W-1:0]         phase_increment;
    logic [ENTRY_W-1:0]         entry_index;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [RATIO_W-1:0]         ratio_value;
    logic [PHASE_W-1:0]         start_phase;

    modport source (
        output valid, kind, phase_increment, entry_index, sample_value, ratio_value,
               start_phase,
        input  ready
    );
    modport sink (
        input  valid, kind, phase_increment, entry_index, sample_value, ratio_value,
               start_phase,
        output ready
    );
endinterface

// File: rtl/uwo_out_if.sv
// output word channel: one stereo sample per tick
interface uwo_out_if;
    import uwo_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, left_sample, right_sample, input ready);
    modport sink (input valid, left_sample, right_sample, output ready);
endinterface

// File: rtl/uwo_ram.sv
// generic single write port ram with registered read
module uwo_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// File: rtl/unison_wavetable_oscillator.sv
// unison wavetable oscillator top level: voice sequencer, hermite datapath, mixer
//
//  channel  dir  handshake          word
//  i_in     in   valid/ready        kind, phase_increment, entry_index, sample_value,
//                                   ratio_value, start_phase
//  o_out    out  valid/ready        left_sample, right_sample
//  cfg      in   i_cfg_we           i_cfg_index, i_cfg_data
//
// a tick works one voice at a time through the phase/ratio rams, four table reads on one port
// and three hermite multiplies
// zero voices: a tick skips the voice states and gives a zero word
// reset clears voice phases to zero and ratios to unity through valid bits, no sweep
// the input stalls while a tick is in work; a finished tick waits only if o_out is stalled
module unison_wavetable_oscillator #(
    parameter int TABLE_LENGTH = 2048,
    parameter int VOICE_LIMIT  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [uwo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uwo_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    uwo_in_if.sink                          i_in,
    uwo_out_if.source                       o_out
);
    import uwo_pkg::*;

    localparam int AW  = (TABLE_LENGTH > 1) ? $clog2(TABLE_LENGTH) : 1;
    localparam int VW  = (VOICE_LIMIT > 1) ? $clog2(VOICE_LIMIT) : 1;
    localparam int CW0 = $clog2(VOICE_LIMIT + 1);
    localparam int CW  = (CW0 > 0) ? CW0 : 1;
    localparam int KW  = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int PW  = PHASE_W + AW + 1;
    localparam int YW  = 24;
    localparam int SW  = 28;
    localparam int MW  = SW + GAIN_W + 1;
    localparam int EW  = 31;
    localparam int GW  = EW + GAIN_W + 1;
    localparam logic [AW:0] TL_W = (AW + 1)'(TABLE_LENGTH);

    typedef enum logic [3:0] {
        S_IDLE, S_RD_V, S_MUL, S_ADD, S_POS, S_T_RD, S_T_LAST,
        S_H0, S_H1, S_H2, S_H3, S_ACC, S_FA, S_FB, S_FC, S_DONE
    } t_state;

    t_state r_state;

    logic [COUNT_W-1:0] r_voice_count;
    logic [GAIN_W-1:0]  r_detune;
    logic [GAIN_W-1:0]  r_level;

    logic [VOICE_LIMIT-1:0] r_ph_vld;
    logic [VOICE_LIMIT-1:0] r_rt_vld;

    logic [CW-1:0]        r_count;
    logic [VW-1:0]        r_voice;
    logic [PHASE_W-1:0]   r_inc;
    logic [PHASE_W-1:0]   r_step;
    logic [PHASE_W-1:0]   r_ph;
    logic [PW-1:0]        r_pos;
    logic [15:0]          r_f;
    logic [1:0]           r_tap;
    logic signed [SAMPLE_W-1:0] r_x [4];
    logic signed [YW-1:0] r_c, r_a, r_b, r_2x0, r_t, r_y, r_y0;
    logic signed [SW-1:0] r_side_l, r_side_r;
    logic signed [MW-1:0] r_m_l, r_m_r;
    logic signed [EW-1:0] r_s_l, r_s_r;
    logic signed [GW-1:0] r_g_l, r_g_r;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r;

    // ram ports
    logic               ph_we;
    logic [VW-1:0]      ph_waddr;
    logic [PHASE_W-1:0] ph_wdata, ph_q;
    logic               rt_we;
    logic [RATIO_W-1:0] rt_q;
    logic               tb_we;
    logic [AW-1:0]      tb_raddr;
    logic [SAMPLE_W-1:0] tb_q;

    logic in_acc;
    logic out_free;
    logic [RATIO_W-1:0] ratio_eff;
    logic [PHASE_W-1:0] phase_eff;
    logic [PHASE_W+RATIO_W-1:0] step_prod;
    logic [AW:0] tap_sum, tap_dec;
    logic signed [YW-1:0] h_c, h_v, h_w, h_a, h_b;
    logic signed [YW+16:0] mul_in, mul_out;
    logic signed [YW-1:0] mul_sh;
    logic signed [GW-PHASE_W-1:0] unused_hi;
    logic signed [PHASE_W-1:0] g_l_sh, g_r_sh;
    logic signed [SAMPLE_W-1:0] sat_l, sat_r;
    logic [CW-1:0] count_next;
    logic voice_last;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid        = r_out_valid;
    assign o_out.left_sample  = r_out_l;
    assign o_out.right_sample = r_out_r;

    assign count_next = (KW'(r_voice_count) > KW'(VOICE_LIMIT)) ? CW'(VOICE_LIMIT)
                                                                  : CW'(r_voice_count);
    assign voice_last = (CW'(r_voice) + CW'(1)) == r_count;

    // ram write steering
    always_comb begin
        ph_we    = 1'b0;
        ph_waddr = r_voice;
        ph_wdata = phase_eff + r_step;
        rt_we    = 1'b0;
        tb_we    = 1'b0;
        if (r_state == S_ADD) begin
            ph_we = 1'b1;
        end else if (in_acc) begin
            ph_waddr = i_in.entry_index[VW-1:0];
            ph_wdata = i_in.start_phase;
            ph_we    = (i_in.kind == KIND_PHASE) &&
                       (32'(i_in.entry_index) < VOICE_LIMIT);
            rt_we    = (i_in.kind == KIND_RATIO) &&
                       (32'(i_in.entry_index) < VOICE_LIMIT);
            tb_we    = (i_in.kind == KIND_SAMPLE) &&
                       (32'(i_in.entry_index) < TABLE_LENGTH);
        end
    end

    assign ratio_eff = r_rt_vld[r_voice] ? rt_q : UNITY_RATIO;
    assign phase_eff = r_ph_vld[r_voice] ? ph_q : '0;
    assign step_prod = PHASE_W'(r_inc) * ratio_eff;

    // neighbor address with wrap
    always_comb begin
        tap_sum = (AW + 1)'(r_pos[PHASE_W +: AW]) + (AW + 1)'(r_tap);
        tap_dec = tap_sum - (AW + 1)'(1);
        if (tap_sum == '0) begin
            tb_raddr = AW'(TL_W - (AW + 1)'(1));
        end else if (tap_dec >= TL_W) begin
            tb_raddr = AW'(tap_dec - TL_W);
        end else begin
            tb_raddr = AW'(tap_dec);
        end
    end

    // hermite coefficients
    always_comb begin
        h_c = YW'(r_x[2]) - YW'(r_x[0]);
        h_v = (YW'(r_x[1]) - YW'(r_x[2])) <<< 1;
        h_w = h_c + h_v;
        h_a = h_w + h_v + (YW'(r_x[3]) - YW'(r_x[1]));
        h_b = h_w + h_a;
    end

    // shared fraction multiplier
    always_comb begin
        case (r_state)
            S_H1:    mul_in = (YW + 17)'(r_a);
            default: mul_in = (YW + 17)'(r_t);
        endcase
        mul_out = mul_in * $signed({1'b0, r_f});
        mul_sh  = YW'(mul_out >>> 16);
    end

    // saturation
    assign g_l_sh = PHASE_W'(r_g_l >>> 16);
    assign g_r_sh = PHASE_W'(r_g_r >>> 16);
    assign unused_hi = '0;
    always_comb begin
        if (g_l_sh > 32'sd32767)       sat_l = 16'sh7fff;
        else if (g_l_sh < -32'sd32768) sat_l = 16'sh8000;
        else                           sat_l = SAMPLE_W'(g_l_sh);
        if (g_r_sh > 32'sd32767)       sat_r = 16'sh7fff;
        else if (g_r_sh < -32'sd32768) sat_r = 16'sh8000;
        else                           sat_r = SAMPLE_W'(g_r_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_voice_count <= RST_VOICE_COUNT;
            r_detune      <= RST_GAIN;
            r_level       <= RST_GAIN;
            r_ph_vld      <= '0;
            r_rt_vld      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VOICE_COUNT:   r_voice_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_DETUNE_AMOUNT: r_detune      <= i_cfg_data[GAIN_W-1:0];
                    CFG_OUTPUT_LEVEL:  r_level       <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ph_we) begin
                r_ph_vld[ph_waddr] <= 1'b1;
            end
            if (rt_we) begin
                r_rt_vld[i_in.entry_index[VW-1:0]] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.kind == KIND_TICK) begin
                        r_inc    <= i_in.phase_increment;
                        r_count  <= count_next;
                        r_voice  <= '0;
                        r_side_l <= '0;
                        r_side_r <= '0;
                        r_g_l    <= '0;
                        r_g_r    <= '0;
                        r_state  <= (count_next == '0) ? S_DONE : S_RD_V;
                    end
                end
                S_RD_V: r_state <= S_MUL;
                S_MUL: begin
                    r_step  <= step_prod[22 +: PHASE_W];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_ph    <= ph_wdata;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_pos   <= PW'(r_ph) * PW'(TL_W);
                    r_tap   <= '0;
                    r_state <= S_T_RD;
                end
                S_T_RD: begin
                    r_f <= r_pos[31:16];
                    if (r_tap != 2'd0) begin
                        r_x[r_tap - 2'd1] <= tb_q;
                    end
                    if (r_tap == 2'd3) begin
                        r_state <= S_T_LAST;
                    end else begin
                        r_tap <= r_tap + 2'd1;
                    end
                end
                S_T_LAST: begin
                    r_x[3]  <= tb_q;
                    r_state <= S_H0;
                end
                S_H0: begin
                    r_c     <= h_c;
                    r_a     <= h_a;
                    r_b     <= h_b;
                    r_2x0   <= YW'(r_x[1]) <<< 1;
                    r_state <= S_H1;
                end
                S_H1: begin
                    r_t     <= mul_sh - r_b;
                    r_state <= S_H2;
                end
                S_H2: begin
                    r_t     <= mul_sh + r_c;
                    r_state <= S_H3;
                end
                S_H3: begin
                    r_y     <= mul_sh + r_2x0 + YW'(unused_hi);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_voice == '0) begin
                        r_y0 <= r_y;
                    end else if (r_voice[0]) begin
                        r_side_r <= r_side_r + SW'(r_y);
                    end else begin
                        r_side_l <= r_side_l + SW'(r_y);
                    end
                    r_voice <= r_voice + VW'(1);
                    r_state <= voice_last ? S_FA : S_RD_V;
                end
                S_FA: begin
                    r_m_l   <= MW'(r_side_l) * $signed({1'b0, r_detune});
                    r_m_r   <= MW'(r_side_r) * $signed({1'b0, r_detune});
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_s_l   <= EW'(r_y0) + EW'(r_m_l >>> 15);
                    r_s_r   <= EW'(r_y0) + EW'(r_m_r >>> 15);
                    r_state <= S_FC;
                end
                S_FC: begin
                    r_g_l   <= GW'(r_s_l) * $signed({1'b0, r_level});
                    r_g_r   <= GW'(r_s_r) * $signed({1'b0, r_level});
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_l     <= sat_l;
                        r_out_r     <= sat_r;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    uwo_ram #(.WIDTH(PHASE_W), .DEPTH(VOICE_LIMIT), .ADDR_W(VW)) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (ph_we),
        .i_waddr (ph_waddr),
        .i_wdata (ph_wdata),
        .i_raddr (r_voice),
        .o_rdata (ph_q)
    );

    uwo_ram #(.WIDTH(RATIO_W), .DEPTH(VOICE_LIMIT), .ADDR_W(VW)) u_ratio_ram (
        .i_clk   (i_clk),
        .i_we    (rt_we),
        .i_waddr (i_in.entry_index[VW-1:0]),
        .i_wdata (i_in.ratio_value),
        .i_raddr (r_voice),
        .o_rdata (rt_q)
    );

    uwo_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_LENGTH), .ADDR_W(AW)) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (tb_we),
        .i_waddr (AW'(i_in.entry_index)),
        .i_wdata (i_in.sample_value),
        .i_raddr (tb_raddr),
        .o_rdata (tb_q)
    );

    a_voice_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (CW'(r_voice) < r_count))
        else $error("voice index beyond active count");

    a_tick_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.kind == KIND_TICK) |=> !i_in.ready)
        else $error("input taken while a tick is in work");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_DONE))
        else $error("output word raised outside the final state");

endmodule

// File: bench/tb_unison_wavetable_oscillator.sv
// self-checking testbench of the unison wavetable oscillator with its own predictor
module tb_unison_wavetable_oscillator;
    timeunit 1ns;
    timeprecision 1ps;
    import uwo_pkg::*;

    localparam int TBL_LEN    = 2048;
    localparam int VOICES     = 16;
    localparam int STALL_MAX  = 200000;
    localparam int LONG_HOLD  = 3000;

    typedef struct packed {
        t_kind                      kind;
        logic [PHASE_W-1:0]         inc;
        logic [ENTRY_W-1:0]         entry;
        logic signed [SAMPLE_W-1:0] sample;
        logic [RATIO_W-1:0]         ratio;
        logic [PHASE_W-1:0]         phase;
    } t_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_stereo;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    uwo_in_if  in_ch ();
    uwo_out_if out_ch ();

    unison_wavetable_oscillator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] wave_mem [TBL_LEN];
    logic [31:0] phase_acc [VOICES];
    logic [23:0] ratio_mem [VOICES];
    int unsigned n_voices;
    longint unsigned detune_gain, level_gain;

    t_word   pending_words [$];
    t_stereo stereo_due [$];
    int errors = 0;
    int unsigned idle_cycles = 0;
    bit hold_recv = 1'b0;
    bit hold_send = 1'b0;
    bit in_taken = 1'b0;
    int burst_left = 0, gap_left = 0;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint hermite_voice(int unsigned vc, logic [31:0] inc);
        longint unsigned stp, pos;
        int unsigned idx;
        longint f, xm1, x0, x1, x2, c, v, w, a, b, t;
        stp = ({32'd0, inc} * {40'd0, ratio_mem[vc]}) >> 22;
        phase_acc[vc] = phase_acc[vc] + stp[31:0];
        pos = {32'd0, phase_acc[vc]} * TBL_LEN;
        idx = (pos >> 32) % TBL_LEN;
        f = longint'((pos >> 16) & 64'hFFFF);
        xm1 = wave_mem[(idx + TBL_LEN - 1) % TBL_LEN];
        x0 = wave_mem[idx];
        x1 = wave_mem[(idx + 1) % TBL_LEN];
        x2 = wave_mem[(idx + 2) % TBL_LEN];
        c = x1 - xm1;
        v = 2 * (x0 - x1);
        w = c + v;
        a = w + v + (x2 - x0);
        b = w + a;
        t = floor_sh(a * f, 16) - b;
        t = floor_sh(t * f, 16) + c;
        return floor_sh(t * f, 16) + 2 * x0;
    endfunction

    function automatic longint sat16(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    task automatic apply_word(t_word w);
        int unsigned cnt;
        longint y0, l, r;
        longint side [2];
        t_stereo res;
        case (w.kind)
            KIND_SAMPLE: if (w.entry < TBL_LEN) wave_mem[w.entry] = w.sample;
            KIND_RATIO:  if (w.entry < VOICES) ratio_mem[w.entry] = w.ratio;
            KIND_PHASE:  if (w.entry < VOICES) phase_acc[w.entry] = w.phase;
            default: begin
                cnt = n_voices > VOICES ? VOICES : n_voices;
                l = 0;
                r = 0;
                if (cnt > 0) begin
                    side[0] = 0;
                    side[1] = 0;
                    y0 = hermite_voice(0, w.inc);
                    for (int i = 1; i < cnt; i++) side[i & 1] += hermite_voice(i, w.inc);
                    l = y0 + floor_sh(side[0] * longint'(detune_gain), 15);
                    r = y0 + floor_sh(side[1] * longint'(detune_gain), 15);
                    l = sat16(floor_sh(l * longint'(level_gain), 16));
                    r = sat16(floor_sh(r * longint'(level_gain), 16));
                end
                res.left = l[15:0];
                res.right = r[15:0];
                stereo_due.push_back(res);
            end
        endcase
    endtask

    // accepted input word seen at the last rising edge
    always @(posedge i_clk) begin
        in_taken <= in_ch.valid && in_ch.ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_words.size() > 0 && !hold_send) begin
                t_word w;
                w = pending_words.pop_front();
                burst_left--;
                in_ch.valid <= 1'b1;
                in_ch.kind <= w.kind;
                in_ch.phase_increment <= w.inc;
                in_ch.entry_index <= w.entry;
                in_ch.sample_value <= w.sample;
                in_ch.ratio_value <= w.ratio;
                in_ch.start_phase <= w.phase;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int unsigned stall_phase = 0;
    int unsigned hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_recv) begin
            hold_left = LONG_HOLD;
            hold_recv = 1'b0;
        end
        stall_phase <= stall_phase + 1;
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (stall_phase[10]) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (in_ch.valid && in_ch.ready) begin
                apply_word(t_word'{in_ch.kind, in_ch.phase_increment, in_ch.entry_index,
                    in_ch.sample_value, in_ch.ratio_value, in_ch.start_phase});
            end
            if (out_ch.valid && out_ch.ready) begin
                if (stereo_due.size() == 0) begin
                    $display("%0t: unexpected word left=%0d right=%0d", $time,
                        out_ch.left_sample, out_ch.right_sample);
                    errors++;
                end else begin
                    t_stereo e;
                    e = stereo_due.pop_front();
                    if (e.left !== out_ch.left_sample) begin
                        $display("%0t: left expected %0d actual %0d", $time, e.left,
                            out_ch.left_sample);
                        errors++;
                    end
                    if (e.right !== out_ch.right_sample) begin
                        $display("%0t: right expected %0d actual %0d", $time, e.right,
                            out_ch.right_sample);
                        errors++;
                    end
                end
            end
            if (idle_cycles > STALL_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic t_word tick_word(logic [31:0] inc);
        t_word w;
        w = '0;
        w.kind = KIND_TICK;
        w.inc = inc;
        return w;
    endfunction

    function automatic t_word write_word(t_kind k, int unsigned entry, logic [31:0] val);
        t_word w;
        w = '0;
        w.kind = k;
        w.entry = entry[10:0];
        w.sample = val[15:0];
        w.ratio = val[23:0];
        w.phase = val;
        w.inc = $urandom;
        return w;
    endfunction

    function automatic logic [31:0] rand_inc();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1 << 20);
            1: return $urandom;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return $urandom_range(0, 32'h0200_0000);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_ch.valid || stereo_due.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_VOICE_COUNT:   n_voices = val[4:0];
            CFG_DETUNE_AMOUNT: detune_gain = val;
            CFG_OUTPUT_LEVEL:  level_gain = val;
            default: ;
        endcase
    endtask

    int n_sent;

    initial begin
        int unsigned counts [6];
        int unsigned gains  [6];
        int unsigned lvl;
        counts = '{16, 0, 31, 5, 2, 9};
        gains  = '{0, 32768, 65535, 12000, 40000, 1};
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_TICK;
        in_ch.phase_increment = '0;
        in_ch.entry_index = '0;
        in_ch.sample_value = '0;
        in_ch.ratio_value = '0;
        in_ch.start_phase = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < VOICES; i++) begin
            phase_acc[i] = '0;
            ratio_mem[i] = UNITY_RATIO;
        end
        n_voices = RST_VOICE_COUNT;
        detune_gain = RST_GAIN;
        level_gain = RST_GAIN;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill whole table so no unwritten entry is read
        for (int i = 0; i < TBL_LEN; i++) begin
            int unsigned v;
            v = (i % 7 == 0) ? ((i & 8) ? 32'h7FFF : 32'h8000) : $urandom;
            pending_words.push_back(write_word(KIND_SAMPLE, i, v));
        end
        // directed
        pending_words.push_back(tick_word(32'd0));
        pending_words.push_back(tick_word(32'hFFFF_FFFF));
        pending_words.push_back(write_word(KIND_SAMPLE, 2047, 32'h7FFF));
        pending_words.push_back(write_word(KIND_RATIO, 0, 32'hFF_FFFF));
        pending_words.push_back(write_word(KIND_RATIO, 16, 32'd5));
        pending_words.push_back(write_word(KIND_RATIO, 2047, 32'd5));
        pending_words.push_back(write_word(KIND_PHASE, 0, 32'hFFFF_FFFF));
        pending_words.push_back(write_word(KIND_PHASE, 20, 32'd1));
        pending_words.push_back(tick_word(32'h8000_0000));
        pending_words.push_back(write_word(KIND_RATIO, 0, 32'd0));
        pending_words.push_back(tick_word(32'h1234_5678));
        pending_words.push_back(write_word(KIND_RATIO, 0, UNITY_RATIO));
        pending_words.push_back(tick_word(32'h0010_0000));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            lvl = (gains[(ph + 3) % 6] == 0) ? 32768 : gains[(ph + 3) % 6];
            write_reg(CFG_VOICE_COUNT, 16'(counts[ph]));
            write_reg(CFG_DETUNE_AMOUNT, 16'(gains[ph]));
            write_reg(CFG_OUTPUT_LEVEL, 16'(lvl));
            write_reg(2'd3, 16'hFFFF);
            n_sent = 0;
            while (n_sent < 40) begin
                int unsigned r;
                r = $urandom_range(0, 9);
                if (r < 6) begin
                    pending_words.push_back(tick_word(rand_inc()));
                end else if (r == 6) begin
                    pending_words.push_back(write_word(KIND_SAMPLE, $urandom_range(0, 2047),
                        $urandom));
                end else if (r == 7) begin
                    pending_words.push_back(write_word(KIND_RATIO, $urandom_range(0, 19),
                        $urandom));
                end else begin
                    pending_words.push_back(write_word(KIND_PHASE, $urandom_range(0, 19),
                        $urandom));
                end
                n_sent++;
            end
            if (ph == 1) begin
                hold_recv = 1'b1;
            end
            if (ph == 3) begin
                while (pending_words.size() > 20) @(posedge i_clk);
                hold_send = 1'b1;
                while (in_ch.valid || stereo_due.size() > 0) @(posedge i_clk);
                hold_send = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
